FILE: rtl/epse_pkg.sv
// Package with widths, codes, reset values and payload types of the encoder speed estimator.
package epse_pkg;

   localparam int TIME_W      = 32;
   localparam int EDGE_W      = 2;
   localparam int POS_W       = 14;
   localparam int NUM_W       = 15;
   localparam int TMO_W       = 16;
   localparam int SPEED_W     = 16;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_STEPS   = NUM_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_NUMERATOR   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_END_POSITION  = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_END_POSITION = CSR_INDEX_W'(3);

   localparam logic [EDGE_W-1:0] EDGE_NONE    = 2'd0;
   localparam logic [EDGE_W-1:0] EDGE_NEG     = 2'd1;
   localparam logic [EDGE_W-1:0] EDGE_POS     = 2'd2;
   localparam logic [EDGE_W-1:0] EDGE_INVALID = 2'd3;

   localparam logic [NUM_W-1:0] RESET_SPEED_NUMERATOR   = NUM_W'(500);
   localparam logic [TMO_W-1:0] RESET_TIMEOUT_TICKS     = TMO_W'(500);
   localparam logic [POS_W-1:0] RESET_LOW_END_POSITION  = POS_W'(40);
   localparam logic [POS_W-1:0] RESET_HIGH_END_POSITION = POS_W'(2390);

   // Multiplying by RECIP_FIVE and dropping RECIP_SHIFT bits divides by five below 1024.
   localparam int RECIP_SHIFT = 10;
   localparam int RECIP_FIVE  = 205;

   typedef struct packed {
      logic [TIME_W-1:0] time_now;
      logic [EDGE_W-1:0] edge_event;
      logic [POS_W-1:0]  position_in;
      logic              low_switch_n;
      logic              high_switch_n;
      logic              sender_idle;
   } req_payload_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] speed;
      logic [POS_W-1:0]          position_out;
      logic                      home_applied;
      logic                      frame_valid;
      logic [BYTE_W-1:0]         frame_pos_high;
      logic [BYTE_W-1:0]         frame_pos_low;
      logic signed [BYTE_W-1:0]  frame_speed;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
   } csr_write_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH
   } state_type;

endpackage

FILE: rtl/epse_ifs.sv
// Handshake interfaces for the request, response and register write channels.
interface epse_req_if import epse_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface epse_rsp_if import epse_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface epse_csr_if import epse_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_write_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/encoder_period_speed_estimator_top.sv
// Encoder period speed estimator: edge timing, iterative speed division, homing and frame build.
// An item that needs a speed division passes through 15 steps of the restoring divider and
// then the finish state; any other item goes straight from acceptance to the finish state.
// The next item is taken only once the finish state has handed its result on and the block is
// idle again, and so later while the previous result is still held by the receiver.
// Synchronous active-high reset restores the register defaults and clears the edge history.
module encoder_period_speed_estimator_top import epse_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   epse_req_if.sink   req_if,
   epse_rsp_if.source rsp_if,
   epse_csr_if.sink   csr_if
);

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

   state_type state_ff, state_in;

   logic [NUM_W-1:0]          num_ff, num_in;
   logic [TMO_W-1:0]          tmo_ff, tmo_in;
   logic [POS_W-1:0]          low_ff, low_in;
   logic [POS_W-1:0]          high_ff, high_in;

   logic [TIME_W-1:0]         last_edge_ff, last_edge_in;
   logic [TIME_W-1:0]         interval_ff, interval_in;
   logic [EDGE_W-1:0]         dir_ff, dir_in;
   logic signed [SPEED_W-1:0] held_ff, held_in;

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [TMO_W-1:0]          rem_ff, rem_in;
   logic [NUM_W-1:0]          quo_ff, quo_in;
   logic [TMO_W-1:0]          divisor_ff, divisor_in;
   logic                      neg_ff, neg_in;

   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      home_ff, home_in;
   logic                      idle_ff, idle_in;
   logic                      lsw_ff, lsw_in;
   logic                      hsw_ff, hsw_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      rsp_free;
   logic                      req_ready;
   logic                      div_done;

   logic [TIME_W-1:0]         elapsed;
   logic                      is_edge;
   logic [TIME_W-1:0]         new_interval;
   logic                      update;
   logic [EDGE_W-1:0]         use_dir;
   logic                      timed_out;
   logic                      need_div;
   logic [POS_W-1:0]          homed_pos;
   logic                      homed;

   logic [TMO_W:0]            shifted;
   logic [TMO_W+1:0]          diff;
   logic                      fits;
   logic [TMO_W-1:0]          rem_next;
   logic [NUM_W-1:0]          quo_next;

   logic [SPEED_W-1:0]        speed_mag;
   logic [BYTE_W+RECIP_SHIFT-1:0] fifth_prod;
   logic [BYTE_W-1:0]         fifth_mag;
   logic [BYTE_W-1:0]         frame_speed;

   assign accept   = req_if.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;
   assign div_done = (cnt_ff == DIV_LAST);

   assign req_if.ready = req_ready;
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // Edge timing and homing of the offered item.
   always_comb begin
      elapsed      = req_if.data.time_now - last_edge_ff;
      is_edge      = (req_if.data.edge_event != EDGE_NONE);
      new_interval = elapsed;
      if (is_edge && elapsed == '0) begin
         new_interval = TIME_W'(1);
      end
      update    = is_edge || (elapsed > interval_ff);
      use_dir   = is_edge ? req_if.data.edge_event : dir_ff;
      timed_out = new_interval > {{(TIME_W-TMO_W){1'b0}}, tmo_ff};
      need_div  = update && !timed_out && (use_dir == EDGE_NEG || use_dir == EDGE_POS);
      homed_pos = req_if.data.position_in;
      homed     = 1'b0;
      if (!req_if.data.low_switch_n) begin
         homed_pos = low_ff;
         homed     = 1'b1;
      end
      if (!req_if.data.high_switch_n) begin
         homed_pos = high_ff;
         homed     = 1'b1;
      end
   end

   // One restoring division step.
   always_comb begin
      shifted  = {rem_ff, quo_ff[NUM_W-1]};
      diff     = {1'b0, shifted} - {2'b00, divisor_ff};
      fits     = !diff[TMO_W+1];
      rem_next = fits ? diff[TMO_W-1:0] : shifted[TMO_W-1:0];
      quo_next = {quo_ff[NUM_W-2:0], fits};
   end

   // Frame speed: held speed divided by five toward zero, saturated to a signed byte.
   always_comb begin
      speed_mag  = held_ff[SPEED_W-1] ? SPEED_W'(-held_ff) : SPEED_W'(held_ff);
      fifth_prod = speed_mag[RECIP_SHIFT-1:0] * BYTE_W'(RECIP_FIVE);
      fifth_mag  = fifth_prod[BYTE_W+RECIP_SHIFT-1:RECIP_SHIFT];
      if (speed_mag[SPEED_W-1:RECIP_SHIFT] != '0) begin
         fifth_mag = '1;
      end
      if (held_ff[SPEED_W-1]) begin
         frame_speed = (fifth_mag > 8'd128) ? 8'h80 : BYTE_W'(~fifth_mag + 8'd1);
      end else begin
         frame_speed = (fifth_mag > 8'd127) ? 8'h7f : fifth_mag;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_div ? ST_DIV : ST_FINISH;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_DIV:    req_ready = 1'b0;
         ST_FINISH: req_ready = 1'b0;
         default:   req_ready = 1'b0;
      endcase
   end

   always_comb begin
      num_in       = num_ff;
      tmo_in       = tmo_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      last_edge_in = last_edge_ff;
      interval_in  = interval_ff;
      dir_in       = dir_ff;
      held_in      = held_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      divisor_in   = divisor_ff;
      neg_in       = neg_ff;
      pos_in       = pos_ff;
      home_in      = home_ff;
      idle_in      = idle_ff;
      lsw_in       = lsw_ff;
      hsw_in       = hsw_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_if.valid) begin
         case (csr_if.data.index)
            CSR_SPEED_NUMERATOR:   num_in  = csr_if.data.value[NUM_W-1:0];
            CSR_TIMEOUT_TICKS:     tmo_in  = csr_if.data.value[TMO_W-1:0];
            CSR_LOW_END_POSITION:  low_in  = csr_if.data.value[POS_W-1:0];
            CSR_HIGH_END_POSITION: high_in = csr_if.data.value[POS_W-1:0];
            default: ;
         endcase
      end

      if (accept) begin
         pos_in  = homed_pos;
         home_in = homed;
         idle_in = req_if.data.sender_idle;
         lsw_in  = req_if.data.low_switch_n;
         hsw_in  = req_if.data.high_switch_n;
         if (update) begin
            interval_in = new_interval;
            if (!need_div) begin
               held_in = '0;
            end
         end
         if (is_edge) begin
            last_edge_in = req_if.data.time_now;
            dir_in       = req_if.data.edge_event;
         end
         if (need_div) begin
            cnt_in     = '0;
            rem_in     = '0;
            quo_in     = num_ff;
            divisor_in = new_interval[TMO_W-1:0];
            neg_in     = (use_dir == EDGE_NEG);
         end
      end

      if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + CNT_W'(1);
         rem_in = rem_next;
         quo_in = quo_next;
         if (div_done) begin
            held_in = neg_ff ? -$signed({1'b0, quo_next}) : $signed({1'b0, quo_next});
         end
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.speed          = held_ff;
         rsp_data_in.position_out   = pos_ff;
         rsp_data_in.home_applied   = home_ff;
         rsp_data_in.frame_valid    = idle_ff;
         rsp_data_in.frame_pos_high = idle_ff ? pos_ff[POS_W-1:POS_W-BYTE_W] : '0;
         rsp_data_in.frame_pos_low  = idle_ff ? {pos_ff[BYTE_W-3:0], hsw_ff, lsw_ff} : '0;
         rsp_data_in.frame_speed    = idle_ff ? frame_speed : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ff       <= RESET_SPEED_NUMERATOR;
         tmo_ff       <= RESET_TIMEOUT_TICKS;
         low_ff       <= RESET_LOW_END_POSITION;
         high_ff      <= RESET_HIGH_END_POSITION;
         last_edge_ff <= '0;
         interval_ff  <= '0;
         dir_ff       <= EDGE_NONE;
         held_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         tmo_ff       <= tmo_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         last_edge_ff <= last_edge_in;
         interval_ff  <= interval_in;
         dir_ff       <= dir_in;
         held_ff      <= held_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      pos_ff      <= pos_in;
      home_ff     <= home_in;
      idle_ff     <= idle_in;
      lsw_ff      <= lsw_in;
      hsw_ff      <= hsw_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // An accepted item keeps the next one from being taken in the cycle after it.
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("request taken in the cycle after an accepted item");

   // A finished item waits while the previous result is still held.
   a_finish_waits : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_if.ready) |=> state_ff == ST_FINISH)
      else $error("finished item left before the held result was taken");

   // A new result only ever comes out of the finish step.
   a_result_from_finish : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) == ST_FINISH)
      else $error("result shown without a finished item");
`endif

endmodule

FILE: test/encoder_period_speed_estimator_top_tb.sv
// Self-checking testbench: the encoder speed estimator is compared item by item with a predictor.
module encoder_period_speed_estimator_top_tb;
   import epse_pkg::*;

   localparam int PHASE_ITEMS   = 240;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 3000;

   logic clock = 1'b0;
   logic reset;

   epse_req_if req_if ();
   epse_rsp_if rsp_if ();
   epse_csr_if csr_if ();

   encoder_period_speed_estimator_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   req_payload_type pending_items[$];
   rsp_payload_type expected_results[$];

   logic [NUM_W-1:0]  cfg_numerator;
   logic [TMO_W-1:0]  cfg_timeout;
   logic [POS_W-1:0]  cfg_low_pos;
   logic [POS_W-1:0]  cfg_high_pos;

   logic [TIME_W-1:0] last_edge_time;
   logic [TIME_W-1:0] edge_interval;
   logic [EDGE_W-1:0] last_direction;
   int                held_speed;

   logic [TIME_W-1:0] time_cursor;
   logic              req_taken;
   int                sender_idle_pct;
   int                receiver_idle_pct;
   int                mismatches;
   int                stall_cycles;
   int                hold_requests;
   int                hold_served;
   int                hold_left;

   always #5 clock = ~clock;

   function automatic int speed_for(logic [TIME_W-1:0] interval, logic [EDGE_W-1:0] dir);
      int magnitude;
      if (interval > TIME_W'(cfg_timeout)) begin
         magnitude = 0;
      end else begin
         magnitude = int'(TIME_W'(cfg_numerator) / interval);
      end
      case (dir)
         EDGE_NEG: begin
            return -magnitude;
         end
         EDGE_POS: begin
            return magnitude;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   function automatic rsp_payload_type estimate_speed(req_payload_type item);
      rsp_payload_type   result;
      logic [TIME_W-1:0] elapsed;
      logic [POS_W-1:0]  pos;
      logic              home;
      int                scaled;
      elapsed = item.time_now - last_edge_time;
      pos = item.position_in;
      home = 1'b0;
      if (!item.low_switch_n) begin
         pos = cfg_low_pos;
         home = 1'b1;
      end
      if (!item.high_switch_n) begin
         pos = cfg_high_pos;
         home = 1'b1;
      end
      if (item.edge_event != EDGE_NONE) begin
         edge_interval = (elapsed == '0) ? TIME_W'(1) : elapsed;
         held_speed = speed_for(edge_interval, item.edge_event);
         last_edge_time = item.time_now;
         last_direction = item.edge_event;
      end else if (elapsed > edge_interval) begin
         edge_interval = elapsed;
         held_speed = speed_for(edge_interval, last_direction);
      end
      result = '0;
      result.speed = held_speed[SPEED_W-1:0];
      result.position_out = pos;
      result.home_applied = home;
      result.frame_valid = item.sender_idle;
      if (item.sender_idle) begin
         scaled = held_speed / 5;
         if (scaled > 127) begin
            scaled = 127;
         end
         if (scaled < -128) begin
            scaled = -128;
         end
         result.frame_pos_high = pos[POS_W-1:6];
         result.frame_pos_low = {pos[5:0], item.high_switch_n, item.low_switch_n};
         result.frame_speed = scaled[BYTE_W-1:0];
      end
      return result;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] reg_index,
                                          logic [CSR_DATA_W-1:0] reg_value);
      case (reg_index)
         CSR_SPEED_NUMERATOR: begin
            cfg_numerator = reg_value[NUM_W-1:0];
         end
         CSR_TIMEOUT_TICKS: begin
            cfg_timeout = reg_value[TMO_W-1:0];
         end
         CSR_LOW_END_POSITION: begin
            cfg_low_pos = reg_value[POS_W-1:0];
         end
         CSR_HIGH_END_POSITION: begin
            cfg_high_pos = reg_value[POS_W-1:0];
         end
         default: begin
         end
      endcase
   endfunction

   function automatic req_payload_type make_item(logic [TIME_W-1:0] stamp,
                                                 logic [EDGE_W-1:0] edge_code,
                                                 logic [POS_W-1:0] pos, logic low_n,
                                                 logic high_n, logic idle);
      req_payload_type item;
      item.time_now = stamp;
      item.edge_event = edge_code;
      item.position_in = pos;
      item.low_switch_n = low_n;
      item.high_switch_n = high_n;
      item.sender_idle = idle;
      return item;
   endfunction

   // Time mostly advances by short steps, so that edges give non-zero speeds and
   // decay is seen; occasional jumps cover timeouts and every bit of the counter.
   function automatic req_payload_type random_item(int span);
      int               pick;
      logic [EDGE_W-1:0] edge_code;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         time_cursor = $urandom;
      end else if (pick < 15) begin
         time_cursor = time_cursor + TIME_W'($urandom_range(0, 70000));
      end else if (pick >= 22) begin
         time_cursor = time_cursor + TIME_W'($urandom_range(1, span));
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         edge_code = EDGE_NONE;
      end else if (pick < 70) begin
         edge_code = EDGE_POS;
      end else if (pick < 90) begin
         edge_code = EDGE_NEG;
      end else begin
         edge_code = EDGE_INVALID;
      end
      return make_item(time_cursor, edge_code, POS_W'($urandom),
                       $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                       $urandom_range(0, 4) != 0);
   endfunction

   task automatic queue_random(int count, int span);
      repeat (count) begin
         pending_items.push_back(random_item(span));
      end
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] reg_index,
                            logic [CSR_DATA_W-1:0] reg_value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data.index <= reg_index;
      csr_if.data.value <= reg_value;
      do @(posedge clock); while (!csr_if.ready);
      apply_register(reg_index, reg_value);
   endtask

   // Bits above the numerator's and the positions' widths are filled at random; the block must drop them.
   task automatic apply_settings(logic [NUM_W-1:0] numerator, logic [TMO_W-1:0] timeout,
                                 logic [POS_W-1:0] low_pos, logic [POS_W-1:0] high_pos);
      csr_write(CSR_SPEED_NUMERATOR, {1'($urandom), numerator});
      csr_write(CSR_TIMEOUT_TICKS, timeout);
      csr_write(CSR_LOW_END_POSITION, {2'($urandom), low_pos});
      csr_write(CSR_HIGH_END_POSITION, {2'($urandom), high_pos});
      csr_write(CSR_INDEX_W'($urandom_range(int'(CSR_HIGH_END_POSITION) + 1,
                                            (1 << CSR_INDEX_W) - 1)),
                CSR_DATA_W'($urandom));
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || expected_results.size() != 0 || req_if.valid) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string field_name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch in %s: expected %0h, got %0h", field_name, want, got);
         end
      end
   endtask

   always @(negedge clock) begin
      if (!reset && (!req_if.valid || req_taken)) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_if.data <= pending_items.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (hold_served != hold_requests) begin
         hold_left = HOLD_CYCLES;
         hold_served++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Result with nothing expected: %p", rsp_if.data);
               end
            end else begin
               want = expected_results.pop_front();
               check_field("speed", want.speed, rsp_if.data.speed);
               check_field("position_out", want.position_out, rsp_if.data.position_out);
               check_field("home_applied", want.home_applied, rsp_if.data.home_applied);
               check_field("frame_valid", want.frame_valid, rsp_if.data.frame_valid);
               check_field("frame_pos_high", want.frame_pos_high, rsp_if.data.frame_pos_high);
               check_field("frame_pos_low", want.frame_pos_low, rsp_if.data.frame_pos_low);
               check_field("frame_speed", want.frame_speed, rsp_if.data.frame_speed);
            end
         end
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(estimate_speed(req_if.data));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles == STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      cfg_numerator = RESET_SPEED_NUMERATOR;
      cfg_timeout = RESET_TIMEOUT_TICKS;
      cfg_low_pos = RESET_LOW_END_POSITION;
      cfg_high_pos = RESET_HIGH_END_POSITION;
      last_edge_time = '0;
      edge_interval = '0;
      last_direction = EDGE_NONE;
      held_speed = 0;
      time_cursor = '0;
      req_taken = 1'b0;
      mismatches = 0;
      stall_cycles = 0;
      hold_requests = 0;
      hold_served = 0;
      hold_left = 0;
      sender_idle_pct = 8;
      receiver_idle_pct = 71;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edges, zero intervals, decay with and without a direction, the timeout
      // boundary, both switches, a busy sender and a wrapping tick counter.
      pending_items.push_back(make_item(100, EDGE_NONE, 14'd0, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(110, EDGE_POS, 14'h3FFF, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(110, EDGE_POS, 14'h2AAA, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(111, EDGE_NEG, 14'h1555, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(112, EDGE_NONE, 14'd123, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(115, EDGE_NONE, 14'd124, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(120, EDGE_INVALID, 14'd125, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(200, EDGE_NONE, 14'd126, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(700, EDGE_POS, 14'd127, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(1201, EDGE_POS, 14'd128, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(1202, EDGE_NEG, 14'd129, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(1212, EDGE_NEG, 14'd130, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(1242, EDGE_NONE, 14'd131, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(1300, EDGE_NONE, 14'd777, 1'b0, 1'b1, 1'b1));
      pending_items.push_back(make_item(1301, EDGE_NONE, 14'd777, 1'b1, 1'b0, 1'b1));
      pending_items.push_back(make_item(1302, EDGE_NONE, 14'd777, 1'b0, 1'b0, 1'b1));
      pending_items.push_back(make_item(1303, EDGE_NONE, 14'd777, 1'b1, 1'b1, 1'b0));
      pending_items.push_back(make_item(32'hFFFF_FFF0, EDGE_POS, 14'd0, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'h0000_0005, EDGE_POS, 14'd1, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'h0000_0005, EDGE_NONE, 14'd2, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'h0000_0005, EDGE_NEG, 14'd3, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'hAAAA_5555, EDGE_NONE, 14'd4, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'h5555_AAAA, EDGE_POS, 14'd5, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'h5555_AAAB, EDGE_POS, 14'd6, 1'b1, 1'b1, 1'b1));
      pending_items.push_back(make_item(32'hFFFF_FFFF, EDGE_NEG, 14'd7, 1'b1, 1'b1, 1'b1));
      wait_until_drained();

      apply_settings(15'd32767, 16'd65535, 14'd0, 14'd16383);
      queue_random(PHASE_ITEMS, 300);
      wait_until_drained();

      apply_settings(15'd1, 16'd1, 14'd16383, 14'd0);
      queue_random(PHASE_ITEMS, 3);
      wait_until_drained();

      sender_idle_pct = 71;
      receiver_idle_pct = 8;
      apply_settings(NUM_W'($urandom_range(1, 32767)), TMO_W'($urandom_range(1, 65535)),
                     POS_W'($urandom), POS_W'($urandom));
      queue_random(PHASE_ITEMS, 200);
      wait_until_drained();

      apply_settings(15'd32767, 16'd1, POS_W'($urandom), POS_W'($urandom));
      queue_random(PHASE_ITEMS, 2);
      wait_until_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      apply_settings(RESET_SPEED_NUMERATOR, RESET_TIMEOUT_TICKS, RESET_LOW_END_POSITION,
                     RESET_HIGH_END_POSITION);
      hold_requests++;
      queue_random(PHASE_ITEMS, 600);
      wait_until_drained();

      apply_settings(NUM_W'($urandom_range(1, 32767)), TMO_W'($urandom_range(1, 65535)),
                     POS_W'($urandom), POS_W'($urandom));
      queue_random(PHASE_ITEMS, 100);
      wait_until_drained();

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
